/* design/dvfs_pkg.sv */
// ----------------------------------------------------------------------------
// dvfs_pkg
// Shared types, register indexes, reset values and constant dividers for the
// DVFS request sequencer.
// ----------------------------------------------------------------------------
package dvfs_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_MIN_VOLTAGE  = 3'd0;
  localparam logic [2:0] CFG_MAX_VOLTAGE  = 3'd1;
  localparam logic [2:0] CFG_MIN_FREQ     = 3'd2;
  localparam logic [2:0] CFG_MAX_FREQ     = 3'd3;
  localparam logic [2:0] CFG_SAFE_VOLTAGE = 3'd4;
  localparam logic [2:0] CFG_SAFE_FREQ    = 3'd5;

  // Reset values
  localparam logic [11:0] RST_MIN_VOLTAGE  = 12'd700;
  localparam logic [11:0] RST_MAX_VOLTAGE  = 12'd1400;
  localparam logic [11:0] RST_MIN_FREQ     = 12'd408;
  localparam logic [11:0] RST_MAX_FREQ     = 12'd1308;
  localparam logic [11:0] RST_SAFE_VOLTAGE = 12'd975;
  localparam logic [11:0] RST_SAFE_FREQ    = 12'd720;
  localparam logic [7:0]  RST_MULTIPLIER   = 8'd60;

  // Command codes
  localparam logic ACT_VOLTAGE = 1'b0;
  localparam logic ACT_PLL     = 1'b1;

  // Grid steps and saturation limits
  localparam logic [12:0] VSTEP_MV  = 13'd25;
  localparam logic [11:0] FSTEP_MHZ = 12'd12;
  localparam logic [7:0]  SEL_MAX   = 8'd31;
  localparam logic [8:0]  MULT_MAX  = 9'd255;

  // Reciprocals: x/25 = (x*1311)>>15 exact for x < 4681,
  //              x/12 = (x*5462)>>16 exact for x < 8192
  localparam logic [10:0] RECIP25 = 11'd1311;
  localparam logic [12:0] RECIP12 = 13'd5462;

  typedef struct packed {
    logic [11:0] req_freq_mhz;
    logic [11:0] req_voltage_mv;
  } dvfs_req_t;

  typedef struct packed {
    logic        action;
    logic [4:0]  voltage_selector;
    logic [7:0]  pll_multiplier;
    logic [11:0] applied_freq_mhz;
    logic [11:0] applied_voltage_mv;
    logic        last;
  } dvfs_cmd_t;

  typedef struct packed {
    logic [11:0] min_voltage_mv;
    logic [11:0] max_voltage_mv;
    logic [11:0] min_freq_mhz;
    logic [11:0] max_freq_mhz;
    logic [11:0] safe_voltage_mv;
    logic [11:0] safe_freq_mhz;
  } dvfs_cfg_t;

  // Quotients of the rounding stage
  typedef struct packed {
    logic [7:0] volt_steps;   // ceil(req_voltage / 25)
    logic [8:0] freq_steps;   // floor(req_freq / 12)
    logic [8:0] safe_steps;   // floor(safe_freq / 12)
  } dvfs_quot_t;

  // Resolved operating point handed to the sequencer
  typedef struct packed {
    logic [11:0] freq_mhz;
    logic [11:0] voltage_mv;
    logic [7:0]  mult;
    logic [11:0] sel_offset;  // voltage above the selector zero point
  } dvfs_item_t;

  function automatic logic [7:0] div25(input logic [12:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'(RECIP25);
    return prod[22:15];
  endfunction

  function automatic logic [8:0] div12(input logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(RECIP12);
    return prod[24:16];
  endfunction

endpackage

/* design/dvfs_request_sequencer_core.sv */
// ----------------------------------------------------------------------------
// dvfs_request_sequencer_core
// DVFS request sequencer: rounds a frequency/voltage request onto the
// regulator and PLL grids and issues the commands in a safe order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid_i / req_stall_o / req_i) carries a requested
//   core frequency and voltage. Command channel (cmd_valid_o / cmd_stall_i /
//   cmd_o) returns one or two commands per request; the final one has last
//   set. A raise sends the voltage command first, a drop sends the PLL
//   command first, an unchanged frequency sends the voltage command only.
//   Out-of-window requests are replaced by the safe operating point.
//   Path: a request passes through the input register, the rounding
//   register and the sequencer hold register, then the command output
//   register.
//   Throughput: one request per cycle when it yields a single command and
//   the command output is not stalled; a request that yields two commands
//   holds the sequencer until both pass the single command output register.
//   Reset clears all pipeline valids, loads the configuration defaults and
//   sets the current PLL multiplier to 60 (720 MHz).
//   A stalled command holds in the output register; the sequencer and the two
//   stages ahead of it keep filling, then req_stall_o rises.
//   Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module dvfs_request_sequencer_core import dvfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  dvfs_req_t   req_i,
  // command channel
  output logic        cmd_valid_o,
  input  logic        cmd_stall_i,
  output dvfs_cmd_t   cmd_o,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i
);

  dvfs_cfg_t  cfg;
  dvfs_quot_t quot;
  dvfs_item_t item;
  logic       quot_vld;
  logic       item_rdy;

  // Limits and safe point
  dvfs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Capture the request and take its grid step counts
  dvfs_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .quot_vld_o  (quot_vld),
    .quot_rdy_i  (item_rdy),
    .quot_o      (quot)
  );

  // Check the window and substitute the safe point where needed
  dvfs_resolve u_resolve (
    .quot_i (quot),
    .cfg_i  (cfg),
    .item_o (item)
  );

  // Order the commands and advance the PLL multiplier
  dvfs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_vld_i  (quot_vld),
    .item_rdy_o  (item_rdy),
    .item_i      (item),
    .cmd_valid_o (cmd_valid_o),
    .cmd_stall_i (cmd_stall_i),
    .cmd_o       (cmd_o)
  );

endmodule

/* design/dvfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dvfs_cfg_regs
// Write-only configuration registers: limits and the safe operating point.
// ----------------------------------------------------------------------------
module dvfs_cfg_regs import dvfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  output dvfs_cfg_t   cfg_o
);

  dvfs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_VOLTAGE:  cfg_d.min_voltage_mv  = cfg_wdata_i;
        CFG_MAX_VOLTAGE:  cfg_d.max_voltage_mv  = cfg_wdata_i;
        CFG_MIN_FREQ:     cfg_d.min_freq_mhz    = cfg_wdata_i;
        CFG_MAX_FREQ:     cfg_d.max_freq_mhz    = cfg_wdata_i;
        CFG_SAFE_VOLTAGE: cfg_d.safe_voltage_mv = cfg_wdata_i;
        CFG_SAFE_FREQ:    cfg_d.safe_freq_mhz   = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_voltage_mv  <= RST_MIN_VOLTAGE;
      cfg_q.max_voltage_mv  <= RST_MAX_VOLTAGE;
      cfg_q.min_freq_mhz    <= RST_MIN_FREQ;
      cfg_q.max_freq_mhz    <= RST_MAX_FREQ;
      cfg_q.safe_voltage_mv <= RST_SAFE_VOLTAGE;
      cfg_q.safe_freq_mhz   <= RST_SAFE_FREQ;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/dvfs_quant.sv */
// ----------------------------------------------------------------------------
// dvfs_quant
// Input register and rounding stage: step counts of the request on the
// 25 mV and 12 MHz grids, plus the step count of the safe frequency.
// ----------------------------------------------------------------------------
module dvfs_quant import dvfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  dvfs_req_t  req_i,
  input  dvfs_cfg_t  cfg_i,
  output logic       quot_vld_o,
  input  logic       quot_rdy_i,
  output dvfs_quot_t quot_o
);

  logic       s1_vld_q;
  dvfs_req_t  s1_req_q;
  logic       s2_vld_q;
  dvfs_quot_t s2_quot_q, s2_quot_d;
  logic       s1_rdy, s2_rdy;

  assign s2_rdy      = !s2_vld_q || quot_rdy_i;
  assign s1_rdy      = !s1_vld_q || s2_rdy;
  assign req_stall_o = !s1_rdy;

  always_comb begin
    s2_quot_d.volt_steps = div25(13'(s1_req_q.req_voltage_mv) + (VSTEP_MV - 13'd1));
    s2_quot_d.freq_steps = div12(s1_req_q.req_freq_mhz);
    s2_quot_d.safe_steps = div12(cfg_i.safe_freq_mhz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_q <= req_valid_i;
      end
      if (s2_rdy) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_valid_i) begin
      s1_req_q <= req_i;
    end
    if (s2_rdy && s1_vld_q) begin
      s2_quot_q <= s2_quot_d;
    end
  end

  assign quot_vld_o = s2_vld_q;
  assign quot_o     = s2_quot_q;

endmodule

/* design/dvfs_resolve.sv */
// ----------------------------------------------------------------------------
// dvfs_resolve
// Window check and safe-point substitution; produces the applied operating
// point, the saturated PLL multiplier and the selector offset.
// ----------------------------------------------------------------------------
module dvfs_resolve import dvfs_pkg::*; (
  input  dvfs_quot_t quot_i,
  input  dvfs_cfg_t  cfg_i,
  output dvfs_item_t item_o
);

  logic [12:0] volt_round;
  logic [11:0] freq_round;
  logic        safe;
  logic [8:0]  steps;

  always_comb begin
    volt_round = 13'(quot_i.volt_steps) * VSTEP_MV;
    freq_round = 12'(quot_i.freq_steps) * FSTEP_MHZ;

    safe = (volt_round < 13'(cfg_i.min_voltage_mv))
        || (volt_round > 13'(cfg_i.max_voltage_mv))
        || (freq_round < cfg_i.min_freq_mhz)
        || (freq_round > cfg_i.max_freq_mhz);

    item_o.voltage_mv = safe ? cfg_i.safe_voltage_mv : volt_round[11:0];
    item_o.freq_mhz   = safe ? cfg_i.safe_freq_mhz   : freq_round;
    steps             = safe ? quot_i.safe_steps     : quot_i.freq_steps;
    item_o.mult       = (steps > MULT_MAX) ? MULT_MAX[7:0] : steps[7:0];

    // Below the zero point the selector is zero
    if (item_o.voltage_mv < cfg_i.min_voltage_mv) begin
      item_o.sel_offset = '0;
    end else begin
      item_o.sel_offset = item_o.voltage_mv - cfg_i.min_voltage_mv;
    end
  end

endmodule

/* design/dvfs_seq.sv */
// ----------------------------------------------------------------------------
// dvfs_seq
// Command sequencer: holds one resolved operating point, orders the voltage
// and PLL commands by direction, and keeps the current PLL multiplier.
// ----------------------------------------------------------------------------
module dvfs_seq import dvfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_vld_i,
  output logic       item_rdy_o,
  input  dvfs_item_t item_i,
  output logic       cmd_valid_o,
  input  logic       cmd_stall_i,
  output dvfs_cmd_t  cmd_o
);

  logic        s3_vld_q;
  dvfs_item_t  item_q;
  logic        phase_q;
  logic        act_first_q;
  logic [7:0]  cur_mult_q;
  logic        out_vld_q;
  dvfs_cmd_t   cmd_q, cmd_d;

  logic [11:0] cur_freq;
  logic        same, lower;
  logic        out_free, out_load, release_item;
  logic [7:0]  sel_steps;

  always_comb begin
    cur_freq     = 12'(cur_mult_q) * FSTEP_MHZ;
    same         = (item_q.freq_mhz == cur_freq);
    lower        = (item_q.freq_mhz < cur_freq);
    out_free     = !out_vld_q || !cmd_stall_i;
    out_load     = s3_vld_q && out_free;
    release_item = out_load && (phase_q || same);
    item_rdy_o   = !s3_vld_q || release_item;

    sel_steps = div25(13'(item_q.sel_offset));
    cmd_d.voltage_selector   = (sel_steps > SEL_MAX) ? SEL_MAX[4:0] : sel_steps[4:0];
    cmd_d.pll_multiplier     = item_q.mult;
    cmd_d.applied_freq_mhz   = item_q.freq_mhz;
    cmd_d.applied_voltage_mv = item_q.voltage_mv;
    if (phase_q) begin
      cmd_d.action = !act_first_q;
      cmd_d.last   = 1'b1;
    end else begin
      cmd_d.action = lower ? ACT_PLL : ACT_VOLTAGE;
      cmd_d.last   = same;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q    <= 1'b0;
      phase_q     <= 1'b0;
      act_first_q <= ACT_VOLTAGE;
      cur_mult_q  <= RST_MULTIPLIER;
      out_vld_q   <= 1'b0;
    end else begin
      if (item_rdy_o) begin
        s3_vld_q <= item_vld_i;
      end
      if (release_item) begin
        phase_q <= 1'b0;
      end else if (out_load && !phase_q) begin
        phase_q <= 1'b1;
      end
      if (out_load && !phase_q) begin
        act_first_q <= cmd_d.action;
        if (!same) begin
          cur_mult_q <= item_q.mult;
        end
      end
      if (out_free) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_rdy_o && item_vld_i) begin
      item_q <= item_i;
    end
    if (out_load) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = out_vld_q;
  assign cmd_o       = cmd_q;

  // The second command only exists while its operating point is held
  a_phase_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> s3_vld_q)
    else $error("second-command phase without a held operating point");

  // A non-final command is always followed by the second phase of the same item
  a_first_leads_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !cmd_d.last) |=> (s3_vld_q && phase_q))
    else $error("non-final command not followed by its second command");

  // The multiplier moves only when a first command with a PLL change goes out
  a_mult_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_mult_q != $past(cur_mult_q)) |-> $past(out_load && !phase_q && !same))
    else $error("PLL multiplier changed without a PLL command");

  // A final command frees the sequencer for the next operating point
  a_last_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && cmd_d.last) |=> !phase_q)
    else $error("final command left the sequencer in its second phase");

endmodule

/* test/dvfs_cmd_checker.sv */
// ----------------------------------------------------------------------------
// dvfs_cmd_checker
// Watches the request, command and configuration ports of the DVFS request
// sequencer, predicts the command transactions for every accepted request and
// compares each accepted command against the oldest prediction.
// ----------------------------------------------------------------------------
module dvfs_cmd_checker import dvfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  dvfs_req_t   req_i,
  input  logic        cmd_valid_i,
  input  logic        cmd_stall_i,
  input  dvfs_cmd_t   cmd_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  output int          outstanding_o,
  output int          fail_count_o
);

  dvfs_cfg_t  window;
  logic [7:0] pll_mult_now;
  dvfs_cmd_t  cmd_due_q[$];

  // Round, fall back to the safe pair when out of window, then order the commands by direction.
  function automatic void sequence_request(input dvfs_req_t r);
    int unsigned f, v, sel, mult, prev_f;
    dvfs_cmd_t   head, tail;
    v = r.req_voltage_mv;
    v = ((v + VSTEP_MV - 1) / VSTEP_MV) * VSTEP_MV;
    f = r.req_freq_mhz;
    f = (f / FSTEP_MHZ) * FSTEP_MHZ;
    if (v < window.min_voltage_mv || v > window.max_voltage_mv ||
        f < window.min_freq_mhz || f > window.max_freq_mhz) begin
      v = window.safe_voltage_mv;
      f = window.safe_freq_mhz;
    end
    sel = (v < window.min_voltage_mv) ? 0 : (v - window.min_voltage_mv) / VSTEP_MV;
    if (sel > SEL_MAX) begin
      sel = SEL_MAX;
    end
    mult = f / FSTEP_MHZ;
    if (mult > MULT_MAX) begin
      mult = MULT_MAX;
    end
    prev_f = pll_mult_now;
    prev_f = prev_f * FSTEP_MHZ;

    head.action             = ACT_VOLTAGE;
    head.voltage_selector   = 5'(sel);
    head.pll_multiplier     = 8'(mult);
    head.applied_freq_mhz   = 12'(f);
    head.applied_voltage_mv = 12'(v);
    head.last               = 1'b1;
    if (f == prev_f) begin
      cmd_due_q.push_back(head);
    end else begin
      tail = head;
      if (f > prev_f) begin
        head.action = ACT_VOLTAGE;
        tail.action = ACT_PLL;
      end else begin
        head.action = ACT_PLL;
        tail.action = ACT_VOLTAGE;
      end
      head.last = 1'b0;
      cmd_due_q.push_back(head);
      cmd_due_q.push_back(tail);
      pll_mult_now = 8'(mult);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: command field %s mismatch: expected %0d, actual %0d",
               $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dvfs_cmd_t want;
    if (!rst_ni) begin
      window.min_voltage_mv  = RST_MIN_VOLTAGE;
      window.max_voltage_mv  = RST_MAX_VOLTAGE;
      window.min_freq_mhz    = RST_MIN_FREQ;
      window.max_freq_mhz    = RST_MAX_FREQ;
      window.safe_voltage_mv = RST_SAFE_VOLTAGE;
      window.safe_freq_mhz   = RST_SAFE_FREQ;
      pll_mult_now           = RST_MULTIPLIER;
      cmd_due_q.delete();
      fail_count_o           = 0;
      outstanding_o         <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_VOLTAGE:  window.min_voltage_mv  = cfg_wdata_i;
          CFG_MAX_VOLTAGE:  window.max_voltage_mv  = cfg_wdata_i;
          CFG_MIN_FREQ:     window.min_freq_mhz    = cfg_wdata_i;
          CFG_MAX_FREQ:     window.max_freq_mhz    = cfg_wdata_i;
          CFG_SAFE_VOLTAGE: window.safe_voltage_mv = cfg_wdata_i;
          CFG_SAFE_FREQ:    window.safe_freq_mhz   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_valid_i && !cmd_stall_i) begin
        if (cmd_due_q.size() == 0) begin
          $display("%0t: unexpected command: expected none, actual %p", $time, cmd_i);
          fail_count_o++;
        end else begin
          want = cmd_due_q.pop_front();
          check_field("action", want.action, cmd_i.action);
          check_field("voltage_selector", want.voltage_selector, cmd_i.voltage_selector);
          check_field("pll_multiplier", want.pll_multiplier, cmd_i.pll_multiplier);
          check_field("applied_freq_mhz", want.applied_freq_mhz, cmd_i.applied_freq_mhz);
          check_field("applied_voltage_mv", want.applied_voltage_mv,
                      cmd_i.applied_voltage_mv);
          check_field("last", want.last, cmd_i.last);
        end
      end
      if (req_valid_i && !req_stall_i) begin
        sequence_request(req_i);
      end
      outstanding_o <= cmd_due_q.size();
    end
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the DVFS request sequencer: directed corner requests over a
// handful of extreme windows, then random requests over several windows with
// random idling on both channels, one long command hold-off and one stretch
// without idling. The command checker judges every transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import dvfs_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 240;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 150;
  localparam int IDLE_PERCENT    = 29;

  // Register indexes the block does not decode; writes to them must be ignored
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam dvfs_cfg_t RESET_WINDOW = '{RST_MIN_VOLTAGE, RST_MAX_VOLTAGE,
                                         RST_MIN_FREQ, RST_MAX_FREQ,
                                         RST_SAFE_VOLTAGE, RST_SAFE_FREQ};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        req_valid;
  logic        req_stall;
  dvfs_req_t   req;
  logic        cmd_valid;
  logic        cmd_stall;
  dvfs_cmd_t   cmd;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [11:0] cfg_wdata;
  int          outstanding;
  int          fail_count;
  int          cycles = 0;

  // Stimulus-side copy of the window, used to aim random requests at it
  dvfs_cfg_t   win;
  logic [11:0] prev_freq;
  // steady: drop all random idling; squeeze_go: ask for the long hold-off
  logic        steady;
  logic        squeeze_go;

  dvfs_request_sequencer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_o (req_stall),
    .req_i       (req),
    .cmd_valid_o (cmd_valid),
    .cmd_stall_i (cmd_stall),
    .cmd_o       (cmd),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  dvfs_cmd_checker u_cmd_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_valid),
    .req_stall_i   (req_stall),
    .req_i         (req),
    .cmd_valid_i   (cmd_valid),
    .cmd_stall_i   (cmd_stall),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always #6 clk = ~clk;

  // Watchdog: fail the run once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("dvfs_request_sequencer_core regression: fail");
      $finish;
    end
  end

  // Command side: stall at random, hold off once for a long stretch so the
  // pipeline fills and the request side backs up, and never stall while the
  // stimulus asks for a steady stretch.
  initial begin
    bit squeezed;
    squeezed = 1'b0;
    cmd_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_go && !squeezed) begin
        squeezed = 1'b1;
        cmd_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      cmd_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Offer one request and hold it until the transaction completes. Idle
  // cycles go in front of it, so valid is never dropped and raised in one step.
  task automatic send_req(input logic [11:0] freq, input logic [11:0] volt);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req.req_freq_mhz   <= freq;
    req.req_voltage_mv <= volt;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Drain every pending command, then load a whole window. The first edge
  // inside the wait lets the checker count a request accepted in this step.
  task automatic program_window(input dvfs_cfg_t c);
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    write_reg(CFG_MIN_VOLTAGE, c.min_voltage_mv);
    write_reg(CFG_MAX_VOLTAGE, c.max_voltage_mv);
    write_reg(CFG_MIN_FREQ, c.min_freq_mhz);
    write_reg(CFG_MAX_FREQ, c.max_freq_mhz);
    write_reg(CFG_SAFE_VOLTAGE, c.safe_voltage_mv);
    write_reg(CFG_SAFE_FREQ, c.safe_freq_mhz);
    write_reg(CFG_SPARE_LO, 12'($urandom_range(0, 4095)));
    write_reg(CFG_SPARE_HI, 12'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
    win = c;
  endtask

  // Random window: mostly sane, with the safe pair inside it half the time.
  function automatic dvfs_cfg_t random_window();
    dvfs_cfg_t c;
    c.min_voltage_mv = 12'($urandom_range(0, 2400));
    c.max_voltage_mv = 12'(c.min_voltage_mv + $urandom_range(0, 1600));
    c.min_freq_mhz   = 12'($urandom_range(0, 2400));
    c.max_freq_mhz   = 12'(c.min_freq_mhz + $urandom_range(0, 1600));
    if ($urandom_range(0, 1) == 1) begin
      c.safe_voltage_mv = 12'($urandom_range(c.min_voltage_mv, c.max_voltage_mv));
      c.safe_freq_mhz   = 12'($urandom_range(c.min_freq_mhz, c.max_freq_mhz));
    end else begin
      c.safe_voltage_mv = 12'($urandom_range(0, 4095));
      c.safe_freq_mhz   = 12'($urandom_range(0, 4095));
    end
    return c;
  endfunction

  // Aim most requests into the window so the direction logic gets exercised;
  // reuse the last frequency now and then to hit the voltage-only case.
  function automatic dvfs_req_t make_request();
    dvfs_req_t r;
    r.req_freq_mhz   = 12'($urandom_range(0, 4095));
    r.req_voltage_mv = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 99) < 75) begin
      r.req_freq_mhz = 12'($urandom_range(win.min_freq_mhz, win.max_freq_mhz));
      r.req_voltage_mv = 12'($urandom_range(
          (win.min_voltage_mv > 24) ? win.min_voltage_mv - 24 : 0, win.max_voltage_mv));
      if ($urandom_range(0, 99) < 20) begin
        r.req_freq_mhz = prev_freq;
      end
    end
    prev_freq = r.req_freq_mhz;
    return r;
  endfunction

  initial begin
    dvfs_cfg_t c;
    dvfs_req_t r;
    rst_n      = 1'b0;
    req_valid  = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_MIN_VOLTAGE;
    cfg_wdata  = '0;
    steady     = 1'b0;
    squeeze_go = 1'b0;
    prev_freq  = RST_SAFE_FREQ;
    win        = RESET_WINDOW;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window, PLL at 720 MHz.
    send_req(12'd720, 12'd975);     // same frequency: voltage command only
    send_req(12'd1319, 12'd1376);   // raise to the window top after rounding
    send_req(12'd419, 12'd676);     // drop to the window bottom after rounding
    send_req(12'd0, 12'd0);         // out of range: safe pair
    send_req(12'd4095, 12'd4095);   // voltage rounds past the field width
    send_req(12'd1000, 12'd4076);   // rounds up to 4100, still out of range
    send_req(12'd1307, 12'd1401);   // voltage rounds just above the max
    send_req(12'd407, 12'd1000);    // frequency rounds just below the min
    send_req(12'd2730, 12'd1365);
    send_req(12'd1365, 12'd2730);

    // Widest window with the safe pair at the top: saturate selector and
    // multiplier.
    c = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095};
    program_window(c);
    send_req(12'd4095, 12'd4095);
    send_req(12'd0, 12'd0);
    send_req(12'd3071, 12'd3060);   // multiplier exactly at its top
    send_req(12'd3072, 12'd25);     // multiplier one past its top
    send_req(12'd3083, 12'd1);

    // Safe pair off the grid and below the selector zero point.
    c = '{12'd2000, 12'd2500, 12'd100, 12'd200, 12'd1013, 12'd1001};
    program_window(c);
    send_req(12'd150, 12'd2250);
    send_req(12'd4000, 12'd100);
    send_req(12'd1001, 12'd1013);

    // All-zero window: only the very bottom is in range.
    c = '0;
    program_window(c);
    send_req(12'd11, 12'd0);
    send_req(12'd12, 12'd0);

    // Inverted window: every request falls back to the safe pair.
    c = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2047, 12'd2047};
    program_window(c);
    send_req(12'd2048, 12'd2048);
    send_req(12'd4095, 12'd4095);

    // Random phases, the first one back on the reset window.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c = (p == 0) ? RESET_WINDOW : random_window();
      program_window(c);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        steady <= (p == 3 && i < 100);
        if (p == 1 && i == 40) begin
          squeeze_go <= 1'b1;
        end
        r = make_request();
        send_req(r.req_freq_mhz, r.req_voltage_mv);
      end
    end

    // Drain, let any stray command show up, then judge.
    req_valid <= 1'b0;
    steady    <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("dvfs_request_sequencer_core regression: pass");
    end else begin
      $display("dvfs_request_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/dvfs_pkg.sv
design/dvfs_cfg_regs.sv
design/dvfs_quant.sv
design/dvfs_resolve.sv
design/dvfs_seq.sv
design/dvfs_request_sequencer_core.sv
test/dvfs_cmd_checker.sv
test/tb_top.sv
